/* design/triangle_heron_area_core_macros.svh */
// assertion macros for the triangle heron area core checker
// no dependencies; taken in by the checker file
`ifndef TRIANGLE_HERON_AREA_CORE_MACROS_SVH
`define TRIANGLE_HERON_AREA_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define THAC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thac check failed");

// next-cycle implication, disabled while in reset
`define THAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thac check failed");

`endif

/* design/thac_pkg.sv */
// shared types, widths and codes for the triangle heron area core
// no dependencies
package thac_pkg;

  localparam int NODE_DEPTH = 1024;
  localparam int FACE_DEPTH = 2048;
  localparam int NODE_AW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int FACE_AW = (FACE_DEPTH > 1) ? $clog2(FACE_DEPTH) : 1;

  localparam int MODE_W   = 2;
  localparam int IDX_W    = 11;
  localparam int COORD_W  = 24;
  localparam int CORNER_W = 10;
  localparam int FACE_W   = 3 * CORNER_W;
  localparam int AREA_W   = 49;

  localparam int DIFF_W = COORD_W + 1;   // coordinate difference, signed
  localparam int LEN_W  = DIFF_W;        // edge length, unsigned q25.0
  localparam int SQ_W   = 2 * LEN_W;     // squared length, unsigned q50.0
  localparam int MUL_W  = LEN_W + 2;     // multiplier operand width
  localparam int FAC_W  = MUL_W + 1;     // signed heron factor
  localparam int PROD_W = 2 * MUL_W;
  localparam int RAD_W  = 2 * PROD_W;    // widest radicand
  localparam int ROOT_W = PROD_W;
  localparam int NB_W   = $clog2(ROOT_W + 1);

  localparam logic [MODE_W-1:0] MODE_NODE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FACE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AREA = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic [IDX_W-1:0]           index;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
    logic [CORNER_W-1:0]        corner_a;
    logic [CORNER_W-1:0]        corner_b;
    logic [CORNER_W-1:0]        corner_c;
  } heron_in_t;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic              clamped;
  } heron_out_t;

  typedef struct packed {
    logic              start;
    logic [NB_W-1:0]   nbits;
  } sqrt_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FACE,
    S_NODE0,
    S_NODE1,
    S_NODE2,
    S_SQ,
    S_ESQRT,
    S_FAC,
    S_MUL,
    S_CHK,
    S_ROOT,
    S_DONE
  } state_e;

endpackage

/* design/thac_store.sv */
// node and face stores, one write and one registered read port each
// depends on thac_pkg
module thac_store (
  input  logic                                 clk_i,
  input  logic                                 node_we_i,
  input  logic [thac_pkg::NODE_AW-1:0]         node_waddr_i,
  input  logic signed [thac_pkg::COORD_W-1:0]  node_wx_i,
  input  logic signed [thac_pkg::COORD_W-1:0]  node_wy_i,
  input  logic signed [thac_pkg::COORD_W-1:0]  node_wz_i,
  input  logic [thac_pkg::NODE_AW-1:0]         node_raddr_i,
  output logic signed [thac_pkg::COORD_W-1:0]  node_rx_o,
  output logic signed [thac_pkg::COORD_W-1:0]  node_ry_o,
  output logic signed [thac_pkg::COORD_W-1:0]  node_rz_o,
  input  logic                                 face_we_i,
  input  logic [thac_pkg::FACE_AW-1:0]         face_waddr_i,
  input  logic [thac_pkg::FACE_W-1:0]          face_wdata_i,
  input  logic [thac_pkg::FACE_AW-1:0]         face_raddr_i,
  output logic [thac_pkg::FACE_W-1:0]          face_rdata_o
);

  logic signed [thac_pkg::COORD_W-1:0] node_x_mem [thac_pkg::NODE_DEPTH];
  logic signed [thac_pkg::COORD_W-1:0] node_y_mem [thac_pkg::NODE_DEPTH];
  logic signed [thac_pkg::COORD_W-1:0] node_z_mem [thac_pkg::NODE_DEPTH];
  logic [thac_pkg::FACE_W-1:0]         face_mem   [thac_pkg::FACE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (node_we_i) begin
      node_x_mem[node_waddr_i] <= node_wx_i;
      node_y_mem[node_waddr_i] <= node_wy_i;
      node_z_mem[node_waddr_i] <= node_wz_i;
    end
    node_rx_o <= node_x_mem[node_raddr_i];
    node_ry_o <= node_y_mem[node_raddr_i];
    node_rz_o <= node_z_mem[node_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (face_we_i) begin
      face_mem[face_waddr_i] <= face_wdata_i;
    end
    face_rdata_o <= face_mem[face_raddr_i];
  end

endmodule

/* design/thac_mul.sv */
// shared unsigned multiplier with registered product
// depends on thac_pkg
module thac_mul (
  input  logic                          clk_i,
  input  logic [thac_pkg::MUL_W-1:0]    a_i,
  input  logic [thac_pkg::MUL_W-1:0]    b_i,
  output logic [thac_pkg::PROD_W-1:0]   p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= thac_pkg::PROD_W'(a_i * b_i);
  end

endmodule

/* design/thac_sqrt.sv */
// shared integer square root, one root bit per cycle (digit recurrence)
// depends on thac_pkg; radicand is left aligned, nbits root bits are formed
module thac_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  thac_pkg::sqrt_ctrl_t          ctrl_i,
  input  logic [thac_pkg::RAD_W-1:0]    rad_i,
  output logic                          done_o,
  output logic [thac_pkg::ROOT_W-1:0]   root_o
);

  localparam int REM_W = thac_pkg::ROOT_W + 2;

  logic                          run_q, done_q;
  logic [thac_pkg::NB_W-1:0]     cnt_q;
  logic [thac_pkg::RAD_W-1:0]    rad_q;
  logic [REM_W-1:0]              rem_q, rem_nx;
  logic [thac_pkg::ROOT_W-1:0]   root_q;
  logic [REM_W+1:0]              cur, sub, diff;
  logic                          ge;

  always_comb begin
    cur    = {rem_q, rad_q[thac_pkg::RAD_W-1 -: 2]};
    sub    = {2'b00, root_q, 2'b01};
    diff   = cur - sub;
    ge     = (cur >= sub);
    rem_nx = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == thac_pkg::NB_W'(1));
      if (ctrl_i.start) begin
        run_q <= 1'b1;
        cnt_q <= ctrl_i.nbits;
      end else if (run_q) begin
        cnt_q <= cnt_q - thac_pkg::NB_W'(1);
        if (cnt_q == thac_pkg::NB_W'(1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q  <= {rad_q[thac_pkg::RAD_W-3:0], 2'b00};
      rem_q  <= rem_nx;
      root_q <= {root_q[thac_pkg::ROOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* design/triangle_heron_area_core.sv */
// top level of the triangle heron area core: sequencer and datapath
// depends on thac_pkg, thac_store, thac_mul, thac_sqrt
//
// channel   | ports                         | handshake
// ----------+-------------------------------+------------------------------
// command   | start_i, busy_o, in_i         | taken when start_i && !busy_o
// result    | result_valid_o, result_o      | one-cycle strobe, no stall
//
// node and face writes leave busy_o low
// an area query holds busy_o up to and including its result strobe: the face and
// node reads, per edge the squares on the multiplier and a root on the square root
// unit, the products, one check and, for a positive product, the final root
// a query with a face index beyond the store strobes its result in the next cycle
// reset clears only the sequencer; the stores hold garbage until written
// the result receiver cannot stall: result_o is valid only while the strobe is high
module triangle_heron_area_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  thac_pkg::heron_in_t   in_i,
  output logic                  result_valid_o,
  output thac_pkg::heron_out_t  result_o
);

  localparam int LEN_W  = thac_pkg::LEN_W;
  localparam int MUL_W  = thac_pkg::MUL_W;
  localparam int FAC_W  = thac_pkg::FAC_W;
  localparam int RAD_W  = thac_pkg::RAD_W;
  localparam int ROOT_W = thac_pkg::ROOT_W;
  localparam int CW     = thac_pkg::CORNER_W;

  thac_pkg::state_e state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] edge_q, edge_d;

  // payload registers
  logic [thac_pkg::FACE_W-1:0]         face_q, face_d;
  logic                                oor_q, oor_d;
  logic signed [thac_pkg::COORD_W-1:0] px_q [3], py_q [3], pz_q [3];
  logic signed [thac_pkg::COORD_W-1:0] px_d [3], py_d [3], pz_d [3];
  logic [LEN_W-1:0]                    len_q [3], len_d [3];
  logic [MUL_W-1:0]                    fmag_q [4], fmag_d [4];
  logic                                neg_q, neg_d;
  logic [thac_pkg::PROD_W-1:0]         m01_q, m01_d, m23_q, m23_d;
  logic [RAD_W-1:0]                    acc_q, acc_d;
  logic [thac_pkg::AREA_W-1:0]         area_q, area_d;
  logic                                clamped_q, clamped_d;

  // store ports
  logic                                node_we, face_we;
  logic [thac_pkg::NODE_AW-1:0]        node_raddr;
  logic signed [thac_pkg::COORD_W-1:0] node_rx, node_ry, node_rz;
  logic [thac_pkg::FACE_W-1:0]         face_rdata;
  logic [CW-1:0]                       corner_rd;

  // shared units
  logic [MUL_W-1:0]                    mul_a, mul_b;
  logic [thac_pkg::PROD_W-1:0]         prod;
  thac_pkg::sqrt_ctrl_t                sq_ctrl;
  logic [RAD_W-1:0]                    sq_rad;
  logic                                sq_done;
  logic [ROOT_W-1:0]                   sq_root;

  // edge difference of the current component
  logic [1:0]                          ia, ib;
  logic signed [thac_pkg::COORD_W-1:0] ca, cb;
  logic signed [thac_pkg::DIFF_W-1:0]  diff;
  logic [thac_pkg::DIFF_W-1:0]         dmag;

  // heron factors
  logic signed [FAC_W-1:0]             per_s, fac [4];

  logic accept;

  assign accept = start_i && !busy_o;

  thac_store u_store (
    .clk_i        (clk_i),
    .node_we_i    (node_we),
    .node_waddr_i (thac_pkg::NODE_AW'(in_i.index)),
    .node_wx_i    (in_i.coord_x),
    .node_wy_i    (in_i.coord_y),
    .node_wz_i    (in_i.coord_z),
    .node_raddr_i (node_raddr),
    .node_rx_o    (node_rx),
    .node_ry_o    (node_ry),
    .node_rz_o    (node_rz),
    .face_we_i    (face_we),
    .face_waddr_i (thac_pkg::FACE_AW'(in_i.index)),
    .face_wdata_i ({in_i.corner_c, in_i.corner_b, in_i.corner_a}),
    .face_raddr_i (thac_pkg::FACE_AW'(in_i.index)),
    .face_rdata_o (face_rdata)
  );

  thac_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  thac_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sq_ctrl),
    .rad_i  (sq_rad),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  // edge endpoints: edge 0 is a-b, edge 1 is b-c, edge 2 is c-a
  always_comb begin
    ia = edge_q;
    ib = (edge_q == 2'd2) ? 2'd0 : edge_q + 2'd1;
    case (cnt_q[1:0])
      2'd0:    begin ca = px_q[ia]; cb = px_q[ib]; end
      2'd1:    begin ca = py_q[ia]; cb = py_q[ib]; end
      default: begin ca = pz_q[ia]; cb = pz_q[ib]; end
    endcase
    diff = thac_pkg::DIFF_W'(ca) - thac_pkg::DIFF_W'(cb);
    dmag = diff[thac_pkg::DIFF_W-1] ? thac_pkg::DIFF_W'(-diff) : diff;
  end

  // doubled half perimeter and the three reduced factors
  always_comb begin
    per_s  = FAC_W'(len_q[0]) + FAC_W'(len_q[1]) + FAC_W'(len_q[2]);
    fac[0] = per_s;
    for (int k = 0; k < 3; k++) begin
      fac[k+1] = per_s - FAC_W'({len_q[k], 1'b0});
    end
  end

  // sequencer and datapath next values
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    edge_d    = edge_q;
    face_d    = face_q;
    oor_d     = 1'b0;
    px_d      = px_q;
    py_d      = py_q;
    pz_d      = pz_q;
    len_d     = len_q;
    fmag_d    = fmag_q;
    neg_d     = neg_q;
    m01_d     = m01_q;
    m23_d     = m23_q;
    acc_d     = acc_q;
    area_d    = area_q;
    clamped_d = clamped_q;
    node_we   = 1'b0;
    face_we   = 1'b0;
    corner_rd = '0;
    mul_a     = '0;
    mul_b     = '0;
    sq_ctrl   = '0;
    sq_rad    = acc_q;

    unique case (state_q)
      thac_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_i.mode)
            thac_pkg::MODE_NODE: node_we = (32'(in_i.index) < thac_pkg::NODE_DEPTH);
            thac_pkg::MODE_FACE: face_we = (32'(in_i.index) < thac_pkg::FACE_DEPTH);
            thac_pkg::MODE_AREA: begin
              area_d    = '0;
              clamped_d = 1'b0;
              // face read is issued in this cycle from the input index
              if (32'(in_i.index) < thac_pkg::FACE_DEPTH) begin
                state_d = thac_pkg::S_FACE;
              end else begin
                state_d = thac_pkg::S_DONE;
              end
            end
            default: ;
          endcase
        end
      end

      thac_pkg::S_FACE: begin
        face_d    = face_rdata;
        corner_rd = face_rdata[CW-1:0];
        oor_d     = (32'(corner_rd) >= thac_pkg::NODE_DEPTH);
        state_d   = thac_pkg::S_NODE0;
      end

      thac_pkg::S_NODE0, thac_pkg::S_NODE1, thac_pkg::S_NODE2: begin
        logic [1:0] slot;
        slot = (state_q == thac_pkg::S_NODE0) ? 2'd0 :
               (state_q == thac_pkg::S_NODE1) ? 2'd1 : 2'd2;
        px_d[slot] = oor_q ? '0 : node_rx;
        py_d[slot] = oor_q ? '0 : node_ry;
        pz_d[slot] = oor_q ? '0 : node_rz;
        corner_rd  = (slot == 2'd0) ? face_q[2*CW-1:CW] : face_q[3*CW-1:2*CW];
        oor_d      = (32'(corner_rd) >= thac_pkg::NODE_DEPTH);
        if (state_q == thac_pkg::S_NODE0) begin
          state_d = thac_pkg::S_NODE1;
        end else if (state_q == thac_pkg::S_NODE1) begin
          state_d = thac_pkg::S_NODE2;
        end else begin
          state_d = thac_pkg::S_SQ;
          cnt_d   = '0;
          edge_d  = '0;
          acc_d   = '0;
        end
      end

      // three squares through the multiplier, each summed in the cycle after it is issued
      thac_pkg::S_SQ: begin
        mul_a = MUL_W'(dmag);
        mul_b = MUL_W'(dmag);
        if (cnt_q != 3'd0) begin
          acc_d = acc_q + RAD_W'(prod);
        end
        if (cnt_q == 3'd3) begin
          sq_ctrl.start = 1'b1;
          sq_ctrl.nbits = thac_pkg::NB_W'(LEN_W);
          sq_rad        = {acc_d[thac_pkg::SQ_W-1:0], (RAD_W - thac_pkg::SQ_W)'(0)};
          state_d       = thac_pkg::S_ESQRT;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end

      thac_pkg::S_ESQRT: begin
        if (sq_done) begin
          len_d[edge_q] = sq_root[LEN_W-1:0];
          cnt_d = '0;
          acc_d = '0;
          if (edge_q == 2'd2) begin
            state_d = thac_pkg::S_FAC;
          end else begin
            edge_d  = edge_q + 2'd1;
            state_d = thac_pkg::S_SQ;
          end
        end
      end

      thac_pkg::S_FAC: begin
        for (int k = 0; k < 4; k++) begin
          fmag_d[k] = fac[k][FAC_W-1] ? MUL_W'(-fac[k]) : fac[k][MUL_W-1:0];
        end
        neg_d   = fac[1][FAC_W-1] ^ fac[2][FAC_W-1] ^ fac[3][FAC_W-1];
        cnt_d   = '0;
        state_d = thac_pkg::S_MUL;
      end

      // pair products, then the wide product in four partial products
      thac_pkg::S_MUL: begin
        cnt_d = cnt_q + 3'd1;
        case (cnt_q)
          3'd0: begin mul_a = fmag_q[0]; mul_b = fmag_q[1]; end
          3'd1: begin mul_a = fmag_q[2]; mul_b = fmag_q[3]; m01_d = prod; end
          3'd2: begin m23_d = prod; acc_d = '0; end
          3'd3: begin mul_a = m01_q[MUL_W-1:0]; mul_b = m23_q[MUL_W-1:0]; end
          3'd4: begin
            mul_a = m01_q[MUL_W-1:0];
            mul_b = m23_q[2*MUL_W-1:MUL_W];
            acc_d = acc_q + RAD_W'(prod);
          end
          3'd5: begin
            mul_a = m01_q[2*MUL_W-1:MUL_W];
            mul_b = m23_q[MUL_W-1:0];
            acc_d = acc_q + (RAD_W'(prod) << MUL_W);
          end
          3'd6: begin
            mul_a = m01_q[2*MUL_W-1:MUL_W];
            mul_b = m23_q[2*MUL_W-1:MUL_W];
            acc_d = acc_q + (RAD_W'(prod) << MUL_W);
          end
          default: begin
            acc_d   = acc_q + (RAD_W'(prod) << (2 * MUL_W));
            state_d = thac_pkg::S_CHK;
          end
        endcase
      end

      thac_pkg::S_CHK: begin
        if (acc_q == '0) begin
          state_d = thac_pkg::S_DONE;
        end else if (neg_q) begin
          // rounding of the lengths drove the product negative
          clamped_d = 1'b1;
          state_d   = thac_pkg::S_DONE;
        end else begin
          sq_ctrl.start = 1'b1;
          sq_ctrl.nbits = thac_pkg::NB_W'(ROOT_W);
          sq_rad        = acc_q;
          state_d       = thac_pkg::S_ROOT;
        end
      end

      // area is root / 4, saturated to the output width
      thac_pkg::S_ROOT: begin
        if (sq_done) begin
          if (sq_root[ROOT_W-1:thac_pkg::AREA_W+2] != '0) begin
            area_d = '1;
          end else begin
            area_d = sq_root[thac_pkg::AREA_W+1:2];
          end
          state_d = thac_pkg::S_DONE;
        end
      end

      thac_pkg::S_DONE: begin
        state_d = thac_pkg::S_IDLE;
      end

      default: state_d = thac_pkg::S_IDLE;
    endcase

    node_raddr = thac_pkg::NODE_AW'(corner_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= thac_pkg::S_IDLE;
      cnt_q   <= '0;
      edge_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      edge_q  <= edge_d;
    end
  end

  always_ff @(posedge clk_i) begin
    face_q    <= face_d;
    oor_q     <= oor_d;
    px_q      <= px_d;
    py_q      <= py_d;
    pz_q      <= pz_d;
    len_q     <= len_d;
    fmag_q    <= fmag_d;
    neg_q     <= neg_d;
    m01_q     <= m01_d;
    m23_q     <= m23_d;
    acc_q     <= acc_d;
    area_q    <= area_d;
    clamped_q <= clamped_d;
  end

  assign busy_o           = (state_q != thac_pkg::S_IDLE);
  assign result_valid_o   = (state_q == thac_pkg::S_DONE);
  assign result_o.area    = area_q;
  assign result_o.clamped = clamped_q;

endmodule

/* design/thac_checker.sv */
// port-level checks for the triangle heron area core, bound to the top level
// depends on thac_pkg and triangle_heron_area_core_macros.svh
`include "triangle_heron_area_core_macros.svh"

module thac_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input thac_pkg::heron_in_t   in_i,
  input logic                  result_valid_o,
  input thac_pkg::heron_out_t  result_o
);

  logic take_query, take_write;

  assign take_query = start_i && !busy_o && (in_i.mode == thac_pkg::MODE_AREA);
  assign take_write = start_i && !busy_o && (in_i.mode != thac_pkg::MODE_AREA);

  // a result only comes while a query transaction is in flight
  `THAC_ASSERT_IMPL(a_result_busy, clk_i, rst_ni, result_valid_o, busy_o)
  // writes never make the block busy
  `THAC_ASSERT_NEXT(a_write_idle, clk_i, rst_ni, take_write, !busy_o && !result_valid_o)
  // a query holds the block until its single result has gone
  `THAC_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, take_query, busy_o)
  `THAC_ASSERT_NEXT(a_result_ends, clk_i, rst_ni, result_valid_o, !busy_o && !result_valid_o)
  // a clamped product carries a zero area
  `THAC_ASSERT_IMPL(a_clamp_zero, clk_i, rst_ni, result_valid_o && result_o.clamped,
                    result_o.area == '0)

endmodule

bind triangle_heron_area_core thac_checker u_thac_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .in_i           (in_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
